FILE: sv/cossim_pkg.sv
// Shared types and constants for the cosine similarity unit.
package cossim_pkg;

  localparam int unsigned ElemW      = 16;
  localparam int unsigned ProdW      = 2 * ElemW;
  localparam int unsigned DotW       = 42;
  localparam int unsigned NormW      = 41;
  localparam int unsigned FracShift  = 16;
  localparam int unsigned RadW       = NormW + FracShift + 1;
  localparam int unsigned RootW      = RadW / 2;
  localparam int unsigned SqRemW     = RootW + 2;
  localparam int unsigned PW         = 2 * RootW;
  localparam int unsigned NumW       = PW + 2;
  localparam int unsigned DivRemW    = PW + 1;
  localparam int unsigned TruthW     = 16;
  localparam int unsigned FloorW     = 32;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned CntW       = 5;
  localparam int unsigned SqrtSteps  = RootW;
  localparam int unsigned DivSteps   = TruthW;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = 1;
  localparam int unsigned CountW     = 2;

  localparam logic [FloorW-1:0] NormFloorReset = FloorW'(1);
  localparam logic              RegNormFloor   = 1'b0;

  typedef struct packed {
    logic signed [ElemW-1:0] a_elem;
    logic signed [ElemW-1:0] b_elem;
    logic                    last_elem;
  } in_req_t;

  typedef struct packed {
    logic [TruthW-1:0] truth;
    logic              degenerate;
  } out_req_t;

  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [NormW-1:0]       norm_a;
    logic [NormW-1:0]       norm_b;
  } sums_t;

endpackage

FILE: sv/cossim_front.sv
// Front end: multiplies each element pair and accumulates dot and squared norms.
module cossim_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cossim_pkg::in_req_t in_req_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output cossim_pkg::sums_t  push_data_o
);
  import cossim_pkg::*;

  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_last_q;
  logic signed [ProdW-1:0] s1_dot_q;
  logic [ProdW-2:0]        s1_na_q, s1_nb_q;
  logic signed [ProdW-1:0] prod_ab, prod_aa, prod_bb;
  logic                    stall;
  sums_t                   acc_q, acc_d, sums;

  assign prod_ab = in_req_i.a_elem * in_req_i.b_elem;
  assign prod_aa = in_req_i.a_elem * in_req_i.a_elem;
  assign prod_bb = in_req_i.b_elem * in_req_i.b_elem;

  assign stall      = s1_valid_q & s1_last_q & ~push_ready_i;
  assign in_ready_o = ~stall;
  assign s1_valid_d = stall | in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && in_valid_i) begin
      s1_last_q <= in_req_i.last_elem;
      s1_dot_q  <= prod_ab;
      s1_na_q   <= prod_aa[ProdW-2:0];
      s1_nb_q   <= prod_bb[ProdW-2:0];
    end
  end

  always_comb begin
    sums.dot    = acc_q.dot + {{(DotW-ProdW){s1_dot_q[ProdW-1]}}, s1_dot_q};
    sums.norm_a = acc_q.norm_a + {{(NormW-ProdW+1){1'b0}}, s1_na_q};
    sums.norm_b = acc_q.norm_b + {{(NormW-ProdW+1){1'b0}}, s1_nb_q};
    acc_d = acc_q;
    if (s1_valid_q && !stall) begin
      acc_d = s1_last_q ? '0 : sums;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign push_valid_o = s1_valid_q & s1_last_q;
  assign push_data_o  = sums;

endmodule

FILE: sv/cossim_queue.sv
// Two-entry queue of finished sums between the front and back ends.
module cossim_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  cossim_pkg::sums_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output cossim_pkg::sums_t pop_data_o
);
  import cossim_pkg::*;

  sums_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != CountW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + CountW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/cossim_back.sv
// Back end: square roots, norm product, floor check and quotient for one vector pair.
module cossim_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  cossim_pkg::sums_t             pop_data_i,
  input  logic [cossim_pkg::FloorW-1:0] norm_floor_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cossim_pkg::out_req_t          out_req_o
);
  import cossim_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StSqrt = 6'b000010,
    StMul  = 6'b000100,
    StChk  = 6'b001000,
    StDiv  = 6'b010000,
    StFin  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_t;

  function automatic sq_t sqrt_step(logic [SqRemW-1:0] rem, logic [RootW-1:0] root,
                                    logic [1:0] digits);
    logic [SqRemW+1:0] rem4;
    logic [SqRemW+1:0] trial;
    sq_t               res;
    rem4  = {rem, digits};
    trial = {2'b00, root, 2'b01};
    if (rem4 >= trial) begin
      res.rem  = SqRemW'(rem4 - trial);
      res.root = {root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = rem4[SqRemW-1:0];
      res.root = {root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [RadW-1:0]        rad_a_q, rad_a_d, rad_b_q, rad_b_d;
  logic [SqRemW-1:0]      sra_q, sra_d, srb_q, srb_d;
  logic [RootW-1:0]       root_a_q, root_a_d, root_b_q, root_b_d;
  logic signed [DotW-1:0] dot_q, dot_d;
  logic [PW-1:0]          p_q, p_d;
  logic [DivRemW-1:0]     rem_q, rem_d;
  logic [TruthW-1:0]      truth_q, truth_d;
  logic                   degen_q, degen_d;
  logic                   out_valid_q, out_valid_d;
  out_req_t               out_q, out_d;

  sq_t                    step_a, step_b;
  logic signed [NumW-1:0] num;
  logic [PW-1:0]          floor_ext;
  logic                   is_degen, num_le0, num_ge2p;
  logic [DivRemW-1:0]     div_r;
  logic                   div_ge;

  assign step_a = sqrt_step(sra_q, root_a_q, rad_a_q[RadW-1 -: 2]);
  assign step_b = sqrt_step(srb_q, root_b_q, rad_b_q[RadW-1 -: 2]);

  assign num = {{(NumW-DotW-FracShift){dot_q[DotW-1]}}, dot_q, {FracShift{1'b0}}}
             + {{(NumW-PW){1'b0}}, p_q};
  assign floor_ext = {{(PW-FloorW-FracShift){1'b0}}, norm_floor_i, {FracShift{1'b0}}};
  assign is_degen  = (p_q == '0) || (p_q < floor_ext);
  assign num_le0   = num[NumW-1] || (num == '0);
  assign num_ge2p  = num >= {{(NumW-PW-1){1'b0}}, p_q, 1'b0};

  assign div_r  = (cnt_q == '0) ? rem_q : {rem_q[DivRemW-2:0], 1'b0};
  assign div_ge = div_r >= {1'b0, p_q};

  assign pop_ready_o = state_q == StIdle;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rad_a_d     = rad_a_q;
    rad_b_d     = rad_b_q;
    sra_d       = sra_q;
    srb_d       = srb_q;
    root_a_d    = root_a_q;
    root_b_d    = root_b_q;
    dot_d       = dot_q;
    p_d         = p_q;
    rem_d       = rem_q;
    truth_d     = truth_q;
    degen_d     = degen_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          rad_a_d  = {1'b0, pop_data_i.norm_a, {FracShift{1'b0}}};
          rad_b_d  = {1'b0, pop_data_i.norm_b, {FracShift{1'b0}}};
          dot_d    = pop_data_i.dot;
          sra_d    = '0;
          srb_d    = '0;
          root_a_d = '0;
          root_b_d = '0;
          cnt_d    = '0;
          state_d  = StSqrt;
        end
      end
      StSqrt: begin
        sra_d    = step_a.rem;
        srb_d    = step_b.rem;
        root_a_d = step_a.root;
        root_b_d = step_b.root;
        rad_a_d  = {rad_a_q[RadW-3:0], 2'b00};
        rad_b_d  = {rad_b_q[RadW-3:0], 2'b00};
        cnt_d    = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        p_d     = root_a_q * root_b_q;
        state_d = StChk;
      end
      StChk: begin
        degen_d = 1'b0;
        truth_d = '0;
        cnt_d   = '0;
        rem_d   = num[DivRemW-1:0];
        if (is_degen) begin
          degen_d = 1'b1;
          state_d = StFin;
        end else if (num_le0) begin
          state_d = StFin;
        end else if (num_ge2p) begin
          truth_d = '1;
          state_d = StFin;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d   = div_ge ? (div_r - {1'b0, p_q}) : div_r;
        truth_d = {truth_q[TruthW-2:0], div_ge};
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.truth      = truth_q;
          out_d.degenerate = degen_q;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rad_a_q  <= rad_a_d;
    rad_b_q  <= rad_b_d;
    sra_q    <= sra_d;
    srb_q    <= srb_d;
    root_a_q <= root_a_d;
    root_b_q <= root_b_d;
    dot_q    <= dot_d;
    p_q      <= p_d;
    rem_q    <= rem_d;
    truth_q  <= truth_d;
    degen_q  <= degen_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: sv/cosine_similarity_unit.sv
// Top level of the cosine similarity unit: config register and front/queue/back wiring.
//
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+-------------------------
//  in       | sink      | in_valid_i / in_ready_o         | in_req_i  (a, b, last)
//  out      | source    | out_valid_o / out_ready_i       | out_req_o (truth, degenerate)
//  config   | sink      | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// The front end takes one element pair per cycle while in_ready_o is high (two-stage
// multiply and accumulate). For each finished vector the back end runs 29 root steps,
// multiply, check, 16 quotient steps, result load and idle; the quotient steps are skipped
// when the check settles it. Two vectors may wait in the queue; input stalls when a last
// pair finds the queue full. Result out stalls only the back end.
// Reset clears control state and accumulators; norm_floor resets to 1. No clearing pass.
module cosine_similarity_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cossim_pkg::in_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cossim_pkg::out_req_t          out_req_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cossim_pkg::AddrW-1:0]  paddr,
  input  logic [cossim_pkg::DataW-1:0]  pwdata,
  output logic [cossim_pkg::DataW-1:0]  prdata,
  output logic                          pready
);
  import cossim_pkg::*;

  logic [FloorW-1:0] norm_floor_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  sums_t             push_data, pop_data;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_floor_q <= NormFloorReset;
    end else if (psel && penable && pwrite && reg_sel == RegNormFloor) begin
      norm_floor_q <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegNormFloor: prdata = norm_floor_q;
      default:      prdata = '0;
    endcase
  end

  cossim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cossim_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cossim_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .norm_floor_i (norm_floor_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_req_o    (out_req_o)
  );

endmodule
